// ===== rtl/iplpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// IPv4 route table package
// Shared types, constants and helper functions for the route table block.
// ----------------------------------------------------------------------------
package iplpr_pkg;

   localparam int ENTRIES   = 64;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int IFACES    = 8;
   localparam int PLEN_W    = 6;
   localparam int MAX_PLEN  = 32;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] dest_addr;
      logic [31:0] gateway_addr;
      logic [31:0] netmask;
      logic [2:0]  iface_id;
      logic [7:0]  route_flags;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] next_hop_gateway;
      logic [2:0]  out_iface;
      logic [7:0]  found_flags;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  flags;
      logic [2:0]  iface;
      logic [PLEN_W-1:0] plen;
   } info_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CHECK,
      S_SHIFT_READ,
      S_SHIFT_WRITE,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_rst;
      logic scan_step;
      logic shift_read;
      logic shift_step;
      logic do_add;
      logic dec_count;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       scan_end;
      logic       del_hit;
      logic       shift_last;
   } sts_type;

   function automatic logic [PLEN_W-1:0] prefix_of(input logic [31:0] mask);
      logic [PLEN_W-1:0] r;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         if (mask[i]) r = PLEN_W'(MAX_PLEN - i);
      end
      return r;
   endfunction

   function automatic logic [31:0] mask_of(input logic [PLEN_W-1:0] len);
      logic [31:0] r;
      if (len == '0) r = '0;
      else if (len >= PLEN_W'(MAX_PLEN)) r = '1;
      else r = 32'hFFFF_FFFF << (PLEN_W'(MAX_PLEN) - len);
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/iplpr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Route table controller
// Sequences add, delete scan with compaction, and lookup scan.
// ----------------------------------------------------------------------------
module iplpr_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire iplpr_pkg::sts_type sts,
   output iplpr_pkg::cmd_type     cmd,
   output logic                   busy
);

   iplpr_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= iplpr_pkg::S_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         iplpr_pkg::S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               cmd.scan_rst = 1'b1;
               state_in = iplpr_pkg::S_READ;
            end
         end
         iplpr_pkg::S_READ: begin
            case (sts.op)
               iplpr_pkg::OP_ADD: begin
                  cmd.do_add = !sts.full;
                  state_in = iplpr_pkg::S_DONE;
               end
               iplpr_pkg::OP_DELETE, iplpr_pkg::OP_LOOKUP: begin
                  if (sts.scan_end) state_in = iplpr_pkg::S_DONE;
                  else state_in = iplpr_pkg::S_CHECK;
               end
               default: state_in = iplpr_pkg::S_DONE;
            endcase
         end
         iplpr_pkg::S_CHECK: begin
            if (sts.op == iplpr_pkg::OP_DELETE && sts.del_hit) begin
               state_in = iplpr_pkg::S_SHIFT_READ;
            end else begin
               cmd.scan_step = 1'b1;
               state_in = iplpr_pkg::S_READ;
            end
         end
         iplpr_pkg::S_SHIFT_READ: begin
            if (sts.shift_last) begin
               cmd.dec_count = 1'b1;
               state_in = iplpr_pkg::S_DONE;
            end else begin
               cmd.shift_read = 1'b1;
               state_in = iplpr_pkg::S_SHIFT_WRITE;
            end
         end
         iplpr_pkg::S_SHIFT_WRITE: begin
            cmd.shift_step = 1'b1;
            state_in = iplpr_pkg::S_SHIFT_READ;
         end
         iplpr_pkg::S_DONE: begin
            cmd.finish = 1'b1;
            state_in = iplpr_pkg::S_IDLE;
         end
         default: state_in = iplpr_pkg::S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/iplpr_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Route table datapath
// Route memory, scan index, best-match tracking and result register.
// ----------------------------------------------------------------------------
module iplpr_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire iplpr_pkg::req_type req,
   input  wire iplpr_pkg::cmd_type cmd,
   input  wire logic [7:0]         up_mask,
   output iplpr_pkg::sts_type      sts,
   output logic                    rsp_valid,
   output iplpr_pkg::rsp_type      rsp
);

   localparam int IW = iplpr_pkg::IDX_W;
   localparam int CW = iplpr_pkg::CNT_W;

   logic [31:0]         mem_dest [iplpr_pkg::ENTRIES];
   logic [31:0]         mem_gw   [iplpr_pkg::ENTRIES];
   iplpr_pkg::info_type mem_info [iplpr_pkg::ENTRIES];

   iplpr_pkg::req_type  req_ff;
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       idx_ff;
   logic                hit_ff;
   logic                done_ok_ff;
   logic [iplpr_pkg::PLEN_W-1:0] best_len_ff;
   logic [31:0]         best_gw_ff;
   iplpr_pkg::info_type best_info_ff;
   logic                rsp_valid_ff;
   iplpr_pkg::rsp_type  rsp_ff, rsp_in;
   logic [iplpr_pkg::PLEN_W-1:0] req_len_ff;
   logic [31:0]         e_dest_ff, e_gw_ff;
   iplpr_pkg::info_type e_info_ff;

   logic [IW-1:0]       rd_addr;
   logic                up, lk_match, del_match;
   logic [31:0]         lmask;

   assign rd_addr  = cmd.shift_read ? IW'(idx_ff + CW'(1)) : idx_ff[IW-1:0];
   assign up       = (32'(e_info_ff.iface) < 32'(iplpr_pkg::IFACES))
                     && up_mask[e_info_ff.iface];
   assign lmask    = iplpr_pkg::mask_of(e_info_ff.plen);
   assign lk_match = up && ((e_dest_ff & lmask) == (req_ff.dest_addr & lmask));
   assign del_match = (e_info_ff.plen == req_len_ff)
                      && ((e_dest_ff & req_ff.netmask) == (req_ff.dest_addr & req_ff.netmask));

   always_comb begin
      sts.op         = req_ff.operation;
      sts.full       = count_ff >= CW'(iplpr_pkg::ENTRIES);
      sts.scan_end   = idx_ff >= count_ff;
      sts.del_hit    = del_match;
      sts.shift_last = (idx_ff + CW'(1)) >= count_ff;
   end

   always_ff @(posedge clock) begin
      e_dest_ff <= mem_dest[rd_addr];
      e_gw_ff   <= mem_gw[rd_addr];
      e_info_ff <= mem_info[rd_addr];
      if (cmd.do_add) begin
         mem_dest[count_ff[IW-1:0]] <= req_ff.dest_addr;
         mem_gw[count_ff[IW-1:0]]   <= req_ff.gateway_addr;
         mem_info[count_ff[IW-1:0]] <= '{flags: req_ff.route_flags, iface: req_ff.iface_id,
                                         plen: req_len_ff};
      end
      if (cmd.shift_step) begin
         mem_dest[idx_ff[IW-1:0]] <= e_dest_ff;
         mem_gw[idx_ff[IW-1:0]]   <= e_gw_ff;
         mem_info[idx_ff[IW-1:0]] <= e_info_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req;
         req_len_ff <= iplpr_pkg::prefix_of(req.netmask);
      end
      if (cmd.scan_rst) idx_ff <= '0;
      else if (cmd.scan_step || cmd.shift_step) idx_ff <= idx_ff + CW'(1);
      if (cmd.scan_rst) done_ok_ff <= 1'b0;
      else if (cmd.do_add || cmd.dec_count) done_ok_ff <= 1'b1;
      if (cmd.scan_rst) hit_ff <= 1'b0;
      else if (cmd.scan_step && lk_match && (!hit_ff || e_info_ff.plen > best_len_ff)) begin
         hit_ff <= 1'b1;
         best_len_ff <= e_info_ff.plen;
         best_gw_ff <= e_gw_ff;
         best_info_ff <= e_info_ff;
      end
      rsp_ff <= rsp_in;
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.finish) begin
         case (req_ff.operation)
            iplpr_pkg::OP_ADD: if (!done_ok_ff) rsp_in.status = iplpr_pkg::ST_FULL;
            iplpr_pkg::OP_DELETE: if (!done_ok_ff) rsp_in.status = iplpr_pkg::ST_NOT_FOUND;
            iplpr_pkg::OP_LOOKUP: begin
               if (hit_ff) begin
                  rsp_in.next_hop_gateway = best_gw_ff;
                  rsp_in.out_iface = best_info_ff.iface;
                  rsp_in.found_flags = best_info_ff.flags;
               end else begin
                  rsp_in.status = iplpr_pkg::ST_NOT_FOUND;
               end
            end
            default: rsp_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.do_add) count_ff <= count_ff + CW'(1);
         else if (cmd.dec_count) count_ff <= count_ff - CW'(1);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/ipv4_longest_prefix_route_table.sv =====
`default_nettype none
// An add passes from the read state to the done state; a delete or lookup visits the
// read and check states for each route in turn. The result beat is registered from done.
// One request at a time; busy is high until the result beat, so the next request
// is accepted at the edge that ends the result beat.
// The result beat lasts one cycle and the receiver cannot stall it.
// Synchronous reset empties the table and sets every interface up.
// ----------------------------------------------------------------------------
// IPv4 longest prefix route table
// Ordered route table with add, delete and longest-prefix lookup.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_route_table (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire iplpr_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output iplpr_pkg::rsp_type      rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [7:0]         csr_wr_data
);

   logic [7:0]         up_mask_ff;
   iplpr_pkg::cmd_type cmd;
   iplpr_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) up_mask_ff <= 8'hFF;
      else if (csr_wr_en) up_mask_ff <= csr_wr_data;
   end

   iplpr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
   );

   iplpr_datapath u_dp (
      .clock(clock), .reset(reset), .req(req_data), .cmd(cmd), .up_mask(up_mask_ff),
      .sts(sts), .rsp_valid(rsp_strobe), .rsp(rsp_data)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      !(cmd.do_add && cmd.dec_count)) else $error("add and remove together");
   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_strobe) else $error("missing result beat");
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("beat without request");

endmodule
`default_nettype wire
